// ===== hdl/csq_pkg.sv =====
package csq_pkg;

   // Request commands. The unused code behaves as a read.
   typedef enum logic [1:0] {
      CMD_WAIT = 2'd0,
      CMD_POST = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_GRANTED = 3'd0,
      ST_BLOCKED = 3'd1,
      ST_POSTED  = 3'd2,
      ST_READ    = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   localparam int PERMIT_BITS = 8;
   localparam logic [PERMIT_BITS-1:0] PERMIT_MAX   = 8'd255;
   localparam logic [PERMIT_BITS-1:0] PERMIT_RESET = 8'd1;

endpackage

// ===== hdl/csq_ram.sv =====
module csq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a FIFO of blocked thread ids (a mutex when the
// permit count is loaded with one).
// Requests arrive on start/req_cmd/req_thread_id and are accepted at a
// clock edge where start is high and busy is low. A wait takes a permit
// if one is free, otherwise it queues the thread id, or reports the queue
// as full. A post pops the oldest waiter, if any, and adds a permit that
// saturates at 255. A read returns the permit count.
// Every request gives exactly one response, presented for one cycle with
// rsp_valid high, in the cycle after the request transfer. The receiver
// cannot stall, so no response is ever held back.
// Throughput is one request per clock while busy is low: the wait queue
// lives in a RAM with a registered read, a post reads the head entry in
// its accept cycle and the popped id appears with the response on the
// next cycle. The csr_ channel loads the permit count and empties the
// queue; during each transfer busy is high and no request is accepted.
// Reset loads a permit count of one and an empty queue; the queue RAM
// itself is not cleared, since no entry is read before written.
module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [ID_BITS-1:0] req_thread_id,
   // Response channel
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic               rsp_woken_valid,
   output logic [ID_BITS-1:0] rsp_woken_thread,
   output logic [7:0]         rsp_permit_value,
   // Configuration channel: initial permit count
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(QUEUE_DEPTH);

   // Architectural state: permit count and queue pointers.
   logic [7:0]           permit_ff, permit_in;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic [2:0]           status_ff, status_in;
   logic                 woken_ff, woken_in;
   logic [7:0]           value_ff;

   logic                 accept;
   logic                 csr_write;
   logic                 ram_we;
   logic                 ram_re;
   logic [ID_BITS-1:0]   ram_rdata;

   // A configuration transfer occupies its cycle; requests wait for it.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign busy      = csr_valid;
   assign accept    = start & ~busy;

   // Decode one request and work out the next state. The queue write of a
   // wait and the head read of a post go straight to the RAM; since each
   // cycle carries one request, the two ports are never used together on
   // the same entry, and a write is visible to a read on any later cycle.
   always_comb begin
      permit_in = permit_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      status_in = csq_pkg::ST_READ;
      woken_in  = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      case (req_cmd)
         csq_pkg::CMD_WAIT: begin
            if (permit_ff != 8'd0) begin
               permit_in = permit_ff - 8'd1;
               status_in = csq_pkg::ST_GRANTED;
            end else if (fill_ff < FILL_MAX) begin
               ram_we    = accept;
               tail_in   = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_BITS'(1);
               fill_in   = fill_ff + FILL_BITS'(1);
               status_in = csq_pkg::ST_BLOCKED;
            end else begin
               status_in = csq_pkg::ST_FULL;
            end
         end
         csq_pkg::CMD_POST: begin
            if (fill_ff != '0) begin
               ram_re   = accept;
               woken_in = 1'b1;
               head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_BITS'(1);
               fill_in  = fill_ff - FILL_BITS'(1);
            end
            if (permit_ff != csq_pkg::PERMIT_MAX) begin
               permit_in = permit_ff + 8'd1;
            end
            status_in = csq_pkg::ST_POSTED;
         end
         default: begin
            // Read, and the unused code, change nothing.
            status_in = csq_pkg::ST_READ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         permit_ff    <= csq_pkg::PERMIT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_write) begin
         // Loading the count also drops every queued waiter.
         permit_ff    <= csr_data;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            permit_ff <= permit_in;
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            fill_ff   <= fill_in;
         end
      end
   end

   // Response payload; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         woken_ff  <= woken_in;
         value_ff  <= permit_in;
      end
   end

   csq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (req_thread_id),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_valid  = woken_ff;
   assign rsp_woken_thread = woken_ff ? ram_rdata : '0;
   assign rsp_permit_value = value_ff;

endmodule
